// ===== rtl/core/integer_divider_32_assert.svh =====
// Assertion macros for the divider RTL.
`ifndef INTEGER_DIVIDER_32_ASSERT_SVH
`define INTEGER_DIVIDER_32_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define IDIV_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define IDIV_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/idiv_pkg.sv =====
// Types shared by the divider controller, datapath and top level.
package idiv_pkg;

  typedef enum logic [1:0] {
    MODE_UQUO,
    MODE_UREM,
    MODE_SQUO,
    MODE_SREM
  } idiv_mode_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FIX
  } idiv_state_e;

  typedef struct packed {
    logic load;
    logic step;
    logic fix;
  } idiv_cmd_t;

endpackage

// ===== rtl/core/integer_divider_32.sv =====
// m_axis_tvalid rises after DATA_WIDTH restoring steps, then one sign fix into the output register;
//   the sign fix waits while the output register still holds a result that was not taken.
// No new word is accepted until the current one has passed its sign fix; the single shared
//   subtract-and-shift unit makes one quotient bit per cycle.
// A new word may be accepted while the previous result waits in the output register.
// Reset (rst_ni low, asynchronous) clears the controller state and output valid.
module integer_divider_32 import idiv_pkg::*; #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [((2*DATA_WIDTH+7)/8)*8-1:0]    s_axis_tdata,  // dividend, divisor
  input  logic [1:0]                           s_axis_tuser,  // mode
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  output logic [((DATA_WIDTH+7)/8)*8-1:0]      m_axis_tdata   // result
);

  localparam int OUT_TDATA_W = ((DATA_WIDTH + 7) / 8) * 8;

  idiv_cmd_t             cmd;
  logic [DATA_WIDTH-1:0] result;

  idiv_ctrl #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (cmd)
  );

  idiv_dp #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk_i      (clk_i),
    .cmd_i      (cmd),
    .mode_i     (idiv_mode_e'(s_axis_tuser)),
    .dividend_i (s_axis_tdata[DATA_WIDTH-1:0]),
    .divisor_i  (s_axis_tdata[2*DATA_WIDTH-1:DATA_WIDTH]),
    .result_o   (result)
  );

  assign m_axis_tdata = OUT_TDATA_W'(result);

endmodule

// ===== rtl/core/idiv_dp.sv =====
// Divider datapath: operand conditioning, shift-subtract step and sign fix.
module idiv_dp import idiv_pkg::*; #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                  clk_i,
  input  idiv_cmd_t             cmd_i,
  input  idiv_mode_e            mode_i,
  input  logic [DATA_WIDTH-1:0] dividend_i,
  input  logic [DATA_WIDTH-1:0] divisor_i,
  output logic [DATA_WIDTH-1:0] result_o
);

  localparam int W = DATA_WIDTH;

  logic [W-1:0] nq_q, nq_d;   // dividend bits shift out at the top, quotient bits in at the bottom
  logic [W-1:0] rem_q, rem_d;
  logic [W-1:0] den_q, den_d;
  logic         rem_sel_q, rem_sel_d;
  logic         a_neg_q, a_neg_d;
  logic         b_neg_q, b_neg_d;
  logic [W-1:0] res_q, res_d;

  logic         is_signed;
  logic [W-1:0] rem_sh;
  logic [W:0]   diff;
  logic         take;
  logic [W-1:0] sel;
  logic         neg;

  assign is_signed = (mode_i == MODE_SQUO) || (mode_i == MODE_SREM);

  // One restoring step; a carry out of the shift always permits the subtract.
  assign rem_sh = {rem_q[W-2:0], nq_q[W-1]};
  assign diff   = {rem_q[W-1], rem_sh} - {1'b0, den_q};
  assign take   = ~diff[W];

  assign sel = rem_sel_q ? rem_q : nq_q;
  assign neg = rem_sel_q ? a_neg_q : (a_neg_q ^ b_neg_q);

  always_comb begin
    nq_d      = nq_q;
    rem_d     = rem_q;
    den_d     = den_q;
    rem_sel_d = rem_sel_q;
    a_neg_d   = a_neg_q;
    b_neg_d   = b_neg_q;
    res_d     = res_q;
    if (cmd_i.load) begin
      a_neg_d   = is_signed & dividend_i[W-1];
      b_neg_d   = is_signed & divisor_i[W-1];
      rem_sel_d = (mode_i == MODE_UREM) || (mode_i == MODE_SREM);
      nq_d      = a_neg_d ? (~dividend_i + W'(1)) : dividend_i;
      den_d     = b_neg_d ? (~divisor_i + W'(1)) : divisor_i;
      rem_d     = '0;
    end
    if (cmd_i.step) begin
      rem_d = take ? diff[W-1:0] : rem_sh;
      nq_d  = {nq_q[W-2:0], take};
    end
    if (cmd_i.fix) begin
      res_d = neg ? (~sel + W'(1)) : sel;
    end
  end

  always_ff @(posedge clk_i) begin
    nq_q      <= nq_d;
    rem_q     <= rem_d;
    den_q     <= den_d;
    rem_sel_q <= rem_sel_d;
    a_neg_q   <= a_neg_d;
    b_neg_q   <= b_neg_d;
    res_q     <= res_d;
  end

  assign result_o = res_q;

endmodule

// ===== rtl/core/idiv_ctrl.sv =====
// Divider controller: handshakes, step counter and output word valid.
`include "integer_divider_32_assert.svh"

module idiv_ctrl import idiv_pkg::*; #(
  parameter int DATA_WIDTH = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output idiv_cmd_t cmd_o
);

  localparam int CNT_W = $clog2(DATA_WIDTH);

  idiv_state_e      state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             out_valid_q, out_valid_d;

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          cnt_d      = CNT_W'(DATA_WIDTH - 1);
          state_d    = ST_RUN;
        end
      end
      ST_RUN: begin
        cmd_o.step = 1'b1;
        if (cnt_q == '0) begin
          state_d = ST_FIX;
        end else begin
          cnt_d = cnt_q - CNT_W'(1);
        end
      end
      ST_FIX: begin
        // hold the finished word until the output register frees up
        if (!out_valid_q || out_ready_i) begin
          cmd_o.fix = 1'b1;
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
    out_valid_d = cmd_o.fix | (out_valid_q & ~out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  `IDIV_ASSERT_NEXT(a_load_starts_run, clk_i, rst_ni, in_valid_i && in_ready_o, (state_q == ST_RUN) && (cnt_q == CNT_W'(DATA_WIDTH - 1)), "accepted word did not start a full run")
  `IDIV_ASSERT_NEXT(a_run_ends_in_fix, clk_i, rst_ni, (state_q == ST_RUN) && (cnt_q == '0), state_q == ST_FIX, "last step not followed by sign fix")
  `IDIV_ASSERT_NEXT(a_fix_sets_valid, clk_i, rst_ni, cmd_o.fix, out_valid_q && (state_q == ST_IDLE), "fixed result not presented")
  `IDIV_ASSERT_IMPLY(a_no_overwrite, clk_i, rst_ni, cmd_o.fix, !out_valid_q || out_ready_i, "pending result overwritten")

endmodule

// ===== sim/tb_integer_divider_32.sv =====
// Self-checking testbench for integer_divider_32: directed table, random words, stalls.
`timescale 1ns / 1ps

module tb_integer_divider_32;
  import idiv_pkg::*;

  localparam int          WIDTH        = 32;
  localparam int          RANDOM_WORDS = 1500;
  localparam int          QUIET_WORDS  = 150;
  localparam int          HOLD_CYCLES  = 600;
  localparam int          DRAIN_CYCLES = 80;
  localparam int unsigned CYCLE_LIMIT  = 600000;
  localparam int          NUM_ROWS     = 25;

  typedef logic [WIDTH-1:0] word_t;

  typedef struct {
    idiv_mode_e mode;
    word_t      dividend;
    word_t      divisor;
    bit         typed;
    word_t      result;
  } stim_row_t;

  typedef struct {
    idiv_mode_e  mode;
    word_t       dividend;
    word_t       divisor;
    word_t       result;
    int unsigned tag;
  } pending_word_t;

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [2*WIDTH-1:0]  s_axis_tdata;   // dividend, divisor
  logic [1:0]          s_axis_tuser;   // mode
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [WIDTH-1:0]    m_axis_tdata;   // result

  pending_word_t pending_results[$];
  int unsigned   fail_count;
  int unsigned   words_sent;
  int unsigned   results_checked;
  int unsigned   zero_divisors;
  int unsigned   mode_count[4];
  int unsigned   cycle_count;
  int            idle_pct;
  bit            quiet;
  bit            hold_output;

  // Signed rows use two's complement words: 0xFFFFFFF9 is -7, 0xFFFFFFFE is -2.
  stim_row_t directed_rows [NUM_ROWS] = '{
    '{MODE_UQUO, 32'd100,        32'd7,        1'b1, 32'd14},
    '{MODE_UREM, 32'd100,        32'd7,        1'b1, 32'd2},
    '{MODE_UQUO, 32'hFFFF_FFFF,  32'd1,        1'b1, 32'hFFFF_FFFF},
    '{MODE_UQUO, 32'hFFFF_FFFF,  32'hFFFF_FFFF, 1'b1, 32'd1},
    '{MODE_UQUO, 32'd0,          32'hFFFF_FFFF, 1'b1, 32'd0},
    '{MODE_UQUO, 32'd5,          32'd0,        1'b1, 32'hFFFF_FFFF},
    '{MODE_UREM, 32'h1234_5678,  32'd0,        1'b1, 32'h1234_5678},
    '{MODE_UREM, 32'hFFFF_FFFF,  32'h10,       1'b1, 32'hF},
    '{MODE_SQUO, 32'd7,          32'd0,        1'b1, 32'hFFFF_FFFF},
    '{MODE_SQUO, 32'hFFFF_FFF9,  32'd0,        1'b1, 32'd1},
    '{MODE_SQUO, 32'd0,          32'd0,        1'b1, 32'hFFFF_FFFF},
    '{MODE_SREM, 32'h8000_0000,  32'd0,        1'b1, 32'h8000_0000},
    '{MODE_SREM, 32'hFFFF_FFF9,  32'd0,        1'b1, 32'hFFFF_FFF9},
    '{MODE_SQUO, 32'h8000_0000,  32'hFFFF_FFFF, 1'b1, 32'h8000_0000},
    '{MODE_SREM, 32'h8000_0000,  32'hFFFF_FFFF, 1'b1, 32'd0},
    '{MODE_SQUO, 32'hFFFF_FFF9,  32'd2,        1'b1, 32'hFFFF_FFFD},
    '{MODE_SREM, 32'hFFFF_FFF9,  32'd2,        1'b1, 32'hFFFF_FFFF},
    '{MODE_SQUO, 32'd7,          32'hFFFF_FFFE, 1'b1, 32'hFFFF_FFFD},
    '{MODE_SREM, 32'd7,          32'hFFFF_FFFE, 1'b1, 32'd1},
    '{MODE_SQUO, 32'hFFFF_FFF9,  32'hFFFF_FFFE, 1'b1, 32'd3},
    '{MODE_SREM, 32'hFFFF_FFF9,  32'hFFFF_FFFE, 1'b1, 32'hFFFF_FFFF},
    '{MODE_SQUO, 32'h7FFF_FFFF,  32'h8000_0000, 1'b0, 32'd0},
    '{MODE_SREM, 32'h7FFF_FFFF,  32'h8000_0000, 1'b0, 32'd0},
    '{MODE_UQUO, 32'h8000_0000,  32'h8000_0000, 1'b0, 32'd0},
    '{MODE_SREM, 32'hDEAD_BEEF,  32'h0001_2345, 1'b0, 32'd0}
  };

  integer_divider_32 #(
    .DATA_WIDTH(WIDTH)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Quotient or remainder as the block defines it, divide by zero included.
  function automatic word_t divider_result(idiv_mode_e mode, word_t dividend, word_t divisor);
    logic  neg_n;
    logic  neg_d;
    word_t mag_n;
    word_t mag_d;
    word_t quo;
    word_t rem;
    neg_n = (mode inside {MODE_SQUO, MODE_SREM}) && dividend[WIDTH-1];
    neg_d = (mode inside {MODE_SQUO, MODE_SREM}) && divisor[WIDTH-1];
    mag_n = neg_n ? word_t'(0) - dividend : dividend;
    mag_d = neg_d ? word_t'(0) - divisor : divisor;
    if (mag_d == '0) begin
      quo = '1;
      rem = mag_n;
    end else begin
      quo = mag_n / mag_d;
      rem = mag_n % mag_d;
    end
    if (mode inside {MODE_UQUO, MODE_SQUO}) begin
      return (neg_n ^ neg_d) ? word_t'(0) - quo : quo;
    end
    return neg_n ? word_t'(0) - rem : rem;
  endfunction

  // Operand mix: corner words, tiny values, words just below all ones, shifted randoms of every width, full randoms.
  function automatic word_t pick_operand();
    word_t corners[5];
    corners = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF};
    case ($urandom_range(0, 9))
      0:       return corners[$urandom_range(0, 4)];
      1:       return word_t'($urandom_range(0, 15));
      2:       return word_t'(32'hFFFF_FFF0 | $urandom_range(0, 15));
      3, 4:    return word_t'($urandom) >> $urandom_range(0, WIDTH - 1);
      default: return word_t'($urandom);
    endcase
  endfunction

  task automatic report_failure(string msg);
    fail_count++;
    if (fail_count <= 10) begin
      $display("[%0t] MISMATCH %s", $realtime, msg);
    end
  endtask

  task automatic send_word(idiv_mode_e mode, word_t dividend, word_t divisor,
                           bit typed, word_t typed_result);
    pending_word_t entry;
    int            gap;
    if (!quiet && idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
      gap = $urandom_range(1, 17);
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= {$urandom, $urandom};
      s_axis_tuser  <= 2'($urandom);
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {divisor, dividend};
    s_axis_tuser  <= mode;
    do @(posedge clk_i); while (!s_axis_tready);
    entry.mode     = mode;
    entry.dividend = dividend;
    entry.divisor  = divisor;
    entry.result   = typed ? typed_result : divider_result(mode, dividend, divisor);
    entry.tag      = words_sent;
    pending_results.push_back(entry);
    words_sent++;
    mode_count[mode]++;
    if (divisor == '0) zero_divisors++;
  endtask

  // Source side: directed table, then random words with shifting idle density.
  initial begin : source
    int         i;
    idiv_mode_e mode;
    rst_ni          = 1'b0;
    s_axis_tvalid   = 1'b0;
    s_axis_tdata    = '0;
    s_axis_tuser    = '0;
    fail_count      = 0;
    words_sent      = 0;
    results_checked = 0;
    zero_divisors   = 0;
    mode_count      = '{default: 0};
    idle_pct        = 30;
    quiet           = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (i = 0; i < NUM_ROWS; i++) begin
      send_word(directed_rows[i].mode, directed_rows[i].dividend, directed_rows[i].divisor,
                directed_rows[i].typed, directed_rows[i].result);
    end

    for (i = 0; i < RANDOM_WORDS; i++) begin
      if (i % 100 == 0) begin
        case ($urandom_range(0, 2))
          0:       idle_pct = 0;
          1:       idle_pct = 15;
          default: idle_pct = 40;
        endcase
      end
      quiet = (i >= RANDOM_WORDS - QUIET_WORDS);
      mode  = idiv_mode_e'($urandom_range(0, 3));
      send_word(mode, pick_operand(), pick_operand(), 1'b0, '0);
    end
    s_axis_tvalid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Sent %0d words (uquo %0d, urem %0d, squo %0d, srem %0d), %0d by zero.",
             words_sent, mode_count[MODE_UQUO], mode_count[MODE_UREM],
             mode_count[MODE_SQUO], mode_count[MODE_SREM], zero_divisors);
    $display("Checked %0d results under random stalls and one long output hold, %0d failures.",
             results_checked, fail_count);
    if (fail_count == 0) begin
      $display("integer_divider_32 verification clean");
    end else begin
      $display("integer_divider_32 verification failed");
    end
    $finish;
  end

  // Sink side: check each accepted word, then pick next cycle's ready.
  initial begin : sink
    int            stall_left;
    pending_word_t entry;
    m_axis_tready = 1'b1;
    stall_left    = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid && m_axis_tready) begin
        results_checked++;
        if (pending_results.size() == 0) begin
          report_failure($sformatf("unexpected result word %h", m_axis_tdata));
        end else begin
          entry = pending_results.pop_front();
          if (m_axis_tdata !== entry.result) begin
            report_failure($sformatf("word %0d mode %s a=%h b=%h: expected %h, got %h",
                                     entry.tag, entry.mode.name(), entry.dividend,
                                     entry.divisor, entry.result, m_axis_tdata));
          end
        end
      end
      if (hold_output) begin
        m_axis_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else if (!quiet && idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
        stall_left = $urandom_range(1, 17) - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Hold the output off long enough that the block backs up into its input.
  initial begin : output_hold
    int held;
    hold_output = 1'b0;
    wait (words_sent >= 200);
    @(posedge clk_i);
    hold_output <= 1'b1;
    for (held = 0; held < HOLD_CYCLES; held++) @(posedge clk_i);
    hold_output <= 1'b0;
  end

  initial cycle_count = 0;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding.",
               cycle_count, pending_results.size());
      $display("integer_divider_32 verification failed");
      $finish;
    end
  end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/idiv_pkg.sv
rtl/core/idiv_dp.sv
rtl/core/idiv_ctrl.sv
rtl/core/integer_divider_32.sv
sim/tb_integer_divider_32.sv
